/* rtl/core/idr_pkg.sv */
`default_nettype none
package idr_pkg;

	localparam int OpW     = 2;
	localparam int WordW   = 32;
	localparam int ConstW  = 24;
	localparam int CodeW   = 6;
	localparam int StatusW = 2;
	localparam int PaddrW  = 3;
	localparam int PdataW  = 32;
	localparam int NibW    = 4;

	localparam logic [OpW-1:0] OP_DECODE   = 2'd0;
	localparam logic [OpW-1:0] OP_REPLACE  = 2'd1;
	localparam logic [OpW-1:0] OP_RELOCATE = 2'd2;

	localparam logic [0:0] REG_RELOCATION_BASE = 1'b0;

	localparam logic [NibW-1:0] TOP_GRP0 = 4'h0;
	localparam logic [NibW-1:0] TOP_GRP1 = 4'h1;
	localparam logic [NibW-1:0] MID_ALU_C = 4'hC;
	localparam logic [NibW-1:0] MID_ALU_D = 4'hD;
	localparam logic [NibW-1:0] MID_ALU_E = 4'hE;
	localparam logic [NibW-1:0] MID_ALU_F = 4'hF;

	localparam logic [CodeW-1:0] CODE_NONE = 6'd0;
	localparam logic [CodeW-1:0] CODE_CALL = 6'd38;
	localparam logic [CodeW-1:0] CODE_LD   = 6'd39;
	localparam logic [CodeW-1:0] CODE_ST   = 6'd40;
	localparam logic [CodeW-1:0] CODE_BZ   = 6'd41;
	localparam logic [CodeW-1:0] CODE_BNZ  = 6'd42;
	localparam logic [CodeW-1:0] CODE_MVIA = 6'd43;

	typedef enum logic [StatusW-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_UNKNOWN  = 2'd1,
		STATUS_NO_CONST = 2'd2,
		STATUS_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [CodeW-1:0]  opcode_code;
		logic [ConstW-1:0] constant_value;
		logic [WordW-1:0]  out_word;
		status_t           status;
	} idr_result_t;

	function automatic logic [CodeW-1:0] grp0_lut(input logic [NibW-1:0] mid);
		logic [CodeW-1:0] r;
		case (mid)
			4'h0: r = 6'd0;
			4'h1: r = 6'd1;
			4'h2: r = 6'd2;
			4'h3: r = 6'd3;
			4'h4: r = 6'd4;
			4'h5: r = 6'd5;
			4'h6: r = 6'd6;
			4'h7: r = 6'd7;
			4'h8: r = 6'd9;
			4'h9: r = 6'd8;
			4'hA: r = 6'd10;
			4'hB: r = 6'd11;
			default: r = CODE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [CodeW-1:0] alu_c_lut(input logic [NibW-1:0] inner);
		logic [CodeW-1:0] r;
		case (inner)
			4'h0: r = 6'd12;
			4'h1: r = 6'd13;
			4'h6: r = 6'd14;
			4'h7: r = 6'd15;
			4'h8: r = 6'd16;
			4'h9: r = 6'd17;
			4'hA: r = 6'd18;
			4'hB: r = 6'd19;
			4'hC: r = 6'd20;
			4'hD: r = 6'd21;
			default: r = CODE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [CodeW-1:0] alu_d_lut(input logic [NibW-1:0] inner);
		logic [CodeW-1:0] r;
		case (inner)
			4'h2: r = 6'd22;
			4'h3: r = 6'd23;
			4'h4: r = 6'd24;
			4'h5: r = 6'd25;
			default: r = CODE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [CodeW-1:0] alu_e_lut(input logic [NibW-1:0] inner);
		logic [CodeW-1:0] r;
		case (inner)
			4'h0: r = 6'd26;
			4'h1: r = 6'd27;
			4'h2: r = 6'd28;
			4'h3: r = 6'd29;
			4'h4: r = 6'd30;
			4'h5: r = 6'd31;
			default: r = CODE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [CodeW-1:0] alu_f_lut(input logic [NibW-1:0] inner);
		logic [CodeW-1:0] r;
		case (inner)
			4'h0: r = 6'd32;
			4'h3: r = 6'd33;
			default: r = CODE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [CodeW-1:0] grp1_lut(input logic [NibW-1:0] mid);
		logic [CodeW-1:0] r;
		case (mid)
			4'h0: r = 6'd34;
			4'h1: r = 6'd35;
			4'h2: r = 6'd36;
			4'h3: r = 6'd37;
			default: r = CODE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [CodeW-1:0] top_lut(input logic [NibW-1:0] top);
		logic [CodeW-1:0] r;
		case (top)
			4'h8: r = CODE_CALL;
			4'h9: r = CODE_LD;
			4'hA: r = CODE_ST;
			4'hB: r = CODE_BZ;
			4'hC: r = CODE_BNZ;
			4'hD: r = CODE_MVIA;
			4'hE: r = 6'd44;
			default: r = CODE_NONE;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/idr_apb_regs.sv */
`default_nettype none
module idr_apb_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [idr_pkg::PaddrW-1:0] paddr,
	input  wire logic [idr_pkg::PdataW-1:0] pwdata,
	output logic      [idr_pkg::PdataW-1:0] prdata,
	output logic                            pready,
	output logic      [idr_pkg::ConstW-1:0] relocation_base
);
	import idr_pkg::*;

	logic [ConstW-1:0] base_q;
	logic              wr_en;
	logic [0:0]        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (wr_en && (reg_idx == REG_RELOCATION_BASE)) begin
			base_q <= pwdata[ConstW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_RELOCATION_BASE) begin
			prdata = {{(PdataW-ConstW){1'b0}}, base_q};
		end
	end

	assign relocation_base = base_q;

endmodule
`default_nettype wire

/* rtl/core/idr_decode.sv */
`default_nettype none
module idr_decode (
	input  wire logic [idr_pkg::OpW-1:0]    op,
	input  wire logic [idr_pkg::WordW-1:0]  instr_word,
	input  wire logic [idr_pkg::ConstW-1:0] new_constant,
	input  wire logic [idr_pkg::ConstW-1:0] relocation_base,
	output idr_pkg::idr_result_t            result
);
	import idr_pkg::*;

	logic [NibW-1:0]   top, mid, inner;
	logic [CodeW-1:0]  code;
	logic              has_const;
	logic [ConstW-1:0] orig_c;
	logic [ConstW-1:0] wr_c;
	logic [ConstW:0]   sum;
	logic [WordW-1:0]  put_w;
	logic              do_write;
	logic              ovf;

	assign top   = instr_word[31:28];
	assign mid   = instr_word[27:24];
	assign inner = instr_word[23:20];

	always_comb begin
		if (top == TOP_GRP0) begin
			case (mid)
				MID_ALU_C: code = alu_c_lut(inner);
				MID_ALU_D: code = alu_d_lut(inner);
				MID_ALU_E: code = alu_e_lut(inner);
				MID_ALU_F: code = alu_f_lut(inner);
				default:   code = grp0_lut(mid);
			endcase
		end else if (top == TOP_GRP1) begin
			code = grp1_lut(mid);
		end else begin
			code = top_lut(top);
		end
	end

	assign has_const = (code >= CODE_CALL) && (code <= CODE_MVIA);

	always_comb begin
		case (code)
			CODE_ST:            orig_c = {instr_word[27:8], instr_word[3:0]};
			CODE_BZ, CODE_BNZ:  orig_c = {instr_word[27:24], instr_word[19:0]};
			default:            orig_c = instr_word[27:4];
		endcase
	end

	assign sum = {1'b0, orig_c} + {1'b0, relocation_base};

	always_comb begin
		case (op)
			OP_REPLACE: begin
				wr_c     = new_constant;
				do_write = 1'b1;
				ovf      = 1'b0;
			end
			OP_RELOCATE: begin
				wr_c     = sum[ConstW-1:0];
				do_write = !sum[ConstW];
				ovf      = sum[ConstW];
			end
			default: begin
				wr_c     = orig_c;
				do_write = 1'b0;
				ovf      = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (code)
			CODE_ST: put_w = {instr_word[31:28], wr_c[23:4], instr_word[7:4], wr_c[3:0]};
			CODE_BZ, CODE_BNZ:
				put_w = {instr_word[31:28], wr_c[23:20], instr_word[23:20], wr_c[19:0]};
			default: put_w = {instr_word[31:28], wr_c, instr_word[3:0]};
		endcase
	end

	always_comb begin
		result.opcode_code    = code;
		result.constant_value = '0;
		result.out_word       = instr_word;
		result.status         = STATUS_OK;
		if (code == CODE_NONE) begin
			result.status = STATUS_UNKNOWN;
		end else if (!has_const) begin
			result.status = STATUS_NO_CONST;
		end else if (ovf) begin
			result.constant_value = orig_c;
			result.status         = STATUS_OVERFLOW;
		end else if (do_write) begin
			result.constant_value = wr_c;
			result.out_word       = put_w;
		end else begin
			result.constant_value = orig_c;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/instruction_decode_and_relocate_unit.sv */
// Decodes one 32-bit instruction word per request into a mnemonic code and,
// for CALL, LD, ST, BZ, BNZ and MVIA, reads, replaces or relocates the
// scattered 24-bit constant. Two register stages: the request is captured,
// then decode, constant shuffle and the 24-bit base add settle combinationally
// into the result register, which holds a result until it is taken. One
// request is taken every cycle while the output is not stalled.
// relocation_base sits at byte address 0 of the APB port and should only be
// written while no request is in flight.
`default_nettype none
module instruction_decode_and_relocate_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [idr_pkg::PaddrW-1:0]  paddr,
	input  wire logic [idr_pkg::PdataW-1:0]  pwdata,
	output logic      [idr_pkg::PdataW-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [idr_pkg::OpW-1:0]     op,
	input  wire logic [idr_pkg::WordW-1:0]   instr_word,
	input  wire logic [idr_pkg::ConstW-1:0]  new_constant,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [idr_pkg::CodeW-1:0]   opcode_code,
	output logic      [idr_pkg::ConstW-1:0]  constant_value,
	output logic      [idr_pkg::WordW-1:0]   out_word,
	output logic      [idr_pkg::StatusW-1:0] status
);
	import idr_pkg::*;

	logic              valid_s1;
	logic [OpW-1:0]    op_s1;
	logic [WordW-1:0]  word_s1;
	logic [ConstW-1:0] newc_s1;
	logic              valid_s2;
	idr_result_t       res_s2;
	idr_result_t       res_d;
	logic [ConstW-1:0] base;
	logic              adv_s1, adv_s2;

	idr_apb_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.relocation_base (base)
	);

	idr_decode u_decode (
		.op              (op_s1),
		.instr_word      (word_s1),
		.new_constant    (newc_s1),
		.relocation_base (base),
		.result          (res_d)
	);

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1   <= op;
			word_s1 <= instr_word;
			newc_s1 <= new_constant;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid      = valid_s2;
	assign opcode_code    = res_s2.opcode_code;
	assign constant_value = res_s2.constant_value;
	assign out_word       = res_s2.out_word;
	assign status         = res_s2.status;

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a full pipeline");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("request lost between stages");

	a_ok_has_const: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (res_s2.status == STATUS_OK)) |->
		((res_s2.opcode_code >= CODE_CALL) && (res_s2.opcode_code <= CODE_MVIA)))
		else $error("ok status on an opcode without constant");

	a_unknown_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (res_s2.status == STATUS_UNKNOWN)) |->
		((res_s2.opcode_code == CODE_NONE) && (res_s2.constant_value == '0)))
		else $error("unrecognised word with code or constant");

endmodule
`default_nettype wire

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import idr_pkg::*;

	localparam logic [OpW-1:0] OP_SPARE = 2'd3;
	localparam logic [PaddrW-1:0] ADDR_BASE = PaddrW'({REG_RELOCATION_BASE, 2'b00});
	localparam logic [PaddrW-1:0] ADDR_STRAY = 3'h4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 125;
	localparam int NROWS = 27;

	typedef enum logic [CodeW-1:0] {
		MN_NONE, MN_RET, MN_RETI, MN_CALLI, MN_PUSH, MN_POP, MN_LDI, MN_STI, MN_BZI,
		MN_BNZI, MN_CMPI, MN_CMPF, MN_MULU, MN_MUL, MN_ADD, MN_SUB, MN_INC, MN_DEC,
		MN_AND, MN_OR, MN_XOR, MN_NOT, MN_DIVU, MN_DIV, MN_REMU, MN_REM, MN_LSL, MN_LSR,
		MN_ROL, MN_ROR, MN_ASL, MN_ASR, MN_FSUB, MN_FADD, MN_FMUL, MN_FDIV, MN_MVIL,
		MN_MVIH, MN_CALL, MN_LD, MN_ST, MN_BZ, MN_BNZ, MN_MVIA, MN_SWI
	} mnemonic_t;

	typedef struct packed {
		mnemonic_t         code;
		logic [ConstW-1:0] cval;
		logic [WordW-1:0]  word;
		status_t           stat;
	} decode_t;

	typedef enum {ROW_ITEM, ROW_BASE, ROW_STRAY} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [OpW-1:0]    opc;
		logic [WordW-1:0]  w;
		logic [ConstW-1:0] nc;
		bit                typed;
		decode_t           want;
	} row_t;

	localparam decode_t UNTYPED = '{MN_NONE, '0, '0, STATUS_OK};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PaddrW-1:0] paddr = '0;
	logic [PdataW-1:0] pwdata = '0;
	logic [PdataW-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OpW-1:0] op = '0;
	logic [WordW-1:0] instr_word = '0;
	logic [ConstW-1:0] new_constant = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CodeW-1:0] opcode_code;
	logic [ConstW-1:0] constant_value;
	logic [WordW-1:0] out_word;
	logic [StatusW-1:0] status;

	logic [ConstW-1:0] reloc_base = '0;
	bit in_calm = 1'b0;
	int mismatches = 0;
	int idle_cycles = 0;
	decode_t decodes_in_flight[$];

	row_t plan [NROWS] = '{
		'{ROW_ITEM, OP_DECODE, 32'h00000000, 24'h000000, 1'b1,
			'{MN_NONE, 24'h000000, 32'h00000000, STATUS_UNKNOWN}},
		'{ROW_ITEM, OP_REPLACE, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1,
			'{MN_NONE, 24'h000000, 32'hFFFFFFFF, STATUS_UNKNOWN}},
		'{ROW_ITEM, OP_RELOCATE, 32'h0C200000, 24'h123456, 1'b1,
			'{MN_NONE, 24'h000000, 32'h0C200000, STATUS_UNKNOWN}},
		'{ROW_ITEM, OP_DECODE, 32'h01000000, 24'h000000, 1'b1,
			'{MN_RET, 24'h000000, 32'h01000000, STATUS_NO_CONST}},
		'{ROW_ITEM, OP_REPLACE, 32'h08000000, 24'hFFFFFF, 1'b1,
			'{MN_BNZI, 24'h000000, 32'h08000000, STATUS_NO_CONST}},
		'{ROW_ITEM, OP_RELOCATE, 32'h09FFFFFF, 24'h000000, 1'b1,
			'{MN_BZI, 24'h000000, 32'h09FFFFFF, STATUS_NO_CONST}},
		'{ROW_ITEM, OP_DECODE, 32'hEFFFFFFF, 24'h000000, 1'b1,
			'{MN_SWI, 24'h000000, 32'hEFFFFFFF, STATUS_NO_CONST}},
		'{ROW_ITEM, OP_DECODE, 32'h8ABCDEF5, 24'h000000, 1'b1,
			'{MN_CALL, 24'hABCDEF, 32'h8ABCDEF5, STATUS_OK}},
		'{ROW_ITEM, OP_REPLACE, 32'h80000000, 24'hFFFFFF, 1'b1,
			'{MN_CALL, 24'hFFFFFF, 32'h8FFFFFF0, STATUS_OK}},
		'{ROW_ITEM, OP_RELOCATE, 32'hDFFFFFFF, 24'h000000, 1'b1,
			'{MN_MVIA, 24'hFFFFFF, 32'hDFFFFFFF, STATUS_OK}},
		'{ROW_ITEM, OP_SPARE, 32'h9123456F, 24'hFFFFFF, 1'b1,
			'{MN_LD, 24'h123456, 32'h9123456F, STATUS_OK}},
		'{ROW_ITEM, OP_REPLACE, 32'hA0000000, 24'hABCDEF, 1'b0, UNTYPED},
		'{ROW_ITEM, OP_REPLACE, 32'hBFFFFFFF, 24'h000000, 1'b0, UNTYPED},
		'{ROW_ITEM, OP_DECODE, 32'hC5A5A5A5, 24'h000000, 1'b0, UNTYPED},
		'{ROW_ITEM, OP_DECODE, 32'h0D300000, 24'h000000, 1'b0, UNTYPED},
		'{ROW_ITEM, OP_DECODE, 32'h0E5FFFFF, 24'h000000, 1'b0, UNTYPED},
		'{ROW_ITEM, OP_DECODE, 32'h0F300000, 24'h000000, 1'b0, UNTYPED},
		'{ROW_ITEM, OP_DECODE, 32'h13000000, 24'h000000, 1'b0, UNTYPED},
		'{ROW_BASE, OP_DECODE, 32'h0, 24'hFFFFFF, 1'b0, UNTYPED},
		'{ROW_ITEM, OP_RELOCATE, 32'h80000010, 24'h000000, 1'b1,
			'{MN_CALL, 24'h000001, 32'h80000010, STATUS_OVERFLOW}},
		'{ROW_ITEM, OP_RELOCATE, 32'h80000000, 24'h000000, 1'b1,
			'{MN_CALL, 24'hFFFFFF, 32'h8FFFFFF0, STATUS_OK}},
		'{ROW_ITEM, OP_RELOCATE, 32'hAFFFFFFF, 24'h000000, 1'b0, UNTYPED},
		'{ROW_STRAY, OP_DECODE, 32'h0, 24'h000000, 1'b0, UNTYPED},
		'{ROW_ITEM, OP_RELOCATE, 32'hC0000000, 24'h000000, 1'b0, UNTYPED},
		'{ROW_BASE, OP_DECODE, 32'h0, 24'h000001, 1'b0, UNTYPED},
		'{ROW_ITEM, OP_RELOCATE, 32'hBF0FFFFF, 24'h000000, 1'b1,
			'{MN_BZ, 24'hFFFFFF, 32'hBF0FFFFF, STATUS_OVERFLOW}},
		'{ROW_ITEM, OP_RELOCATE, 32'h90000000, 24'h000000, 1'b0, UNTYPED}
	};

	instruction_decode_and_relocate_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.instr_word(instr_word),
		.new_constant(new_constant),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.opcode_code(opcode_code),
		.constant_value(constant_value),
		.out_word(out_word),
		.status(status)
	);

	always #6 clk = ~clk;

	function automatic mnemonic_t mnemonic_of(input logic [WordW-1:0] w);
		mnemonic_t m;
		m = MN_NONE;
		case (w[31:28])
			TOP_GRP0: begin
				case (w[27:24])
					4'h1: m = MN_RET;
					4'h2: m = MN_RETI;
					4'h3: m = MN_CALLI;
					4'h4: m = MN_PUSH;
					4'h5: m = MN_POP;
					4'h6: m = MN_LDI;
					4'h7: m = MN_STI;
					4'h8: m = MN_BNZI;
					4'h9: m = MN_BZI;
					4'hA: m = MN_CMPI;
					4'hB: m = MN_CMPF;
					MID_ALU_C: begin
						case (w[23:20])
							4'h0: m = MN_MULU;
							4'h1: m = MN_MUL;
							4'h6: m = MN_ADD;
							4'h7: m = MN_SUB;
							4'h8: m = MN_INC;
							4'h9: m = MN_DEC;
							4'hA: m = MN_AND;
							4'hB: m = MN_OR;
							4'hC: m = MN_XOR;
							4'hD: m = MN_NOT;
							default: m = MN_NONE;
						endcase
					end
					MID_ALU_D: begin
						case (w[23:20])
							4'h2: m = MN_DIVU;
							4'h3: m = MN_DIV;
							4'h4: m = MN_REMU;
							4'h5: m = MN_REM;
							default: m = MN_NONE;
						endcase
					end
					MID_ALU_E: begin
						case (w[23:20])
							4'h0: m = MN_LSL;
							4'h1: m = MN_LSR;
							4'h2: m = MN_ROL;
							4'h3: m = MN_ROR;
							4'h4: m = MN_ASL;
							4'h5: m = MN_ASR;
							default: m = MN_NONE;
						endcase
					end
					MID_ALU_F: begin
						case (w[23:20])
							4'h0: m = MN_FSUB;
							4'h3: m = MN_FADD;
							default: m = MN_NONE;
						endcase
					end
					default: m = MN_NONE;
				endcase
			end
			TOP_GRP1: begin
				case (w[27:24])
					4'h0: m = MN_FMUL;
					4'h1: m = MN_FDIV;
					4'h2: m = MN_MVIL;
					4'h3: m = MN_MVIH;
					default: m = MN_NONE;
				endcase
			end
			4'h8: m = MN_CALL;
			4'h9: m = MN_LD;
			4'hA: m = MN_ST;
			4'hB: m = MN_BZ;
			4'hC: m = MN_BNZ;
			4'hD: m = MN_MVIA;
			4'hE: m = MN_SWI;
			default: m = MN_NONE;
		endcase
		return m;
	endfunction

	// the constant is scattered differently for stores and branches
	function automatic logic [ConstW-1:0] const_field(input mnemonic_t m,
		input logic [WordW-1:0] w);
		case (m)
			MN_ST: return {w[27:8], w[3:0]};
			MN_BZ, MN_BNZ: return {w[27:24], w[19:0]};
			default: return w[27:4];
		endcase
	endfunction

	function automatic logic [WordW-1:0] with_const(input mnemonic_t m,
		input logic [WordW-1:0] w, input logic [ConstW-1:0] c);
		case (m)
			MN_ST: return {w[31:28], c[23:4], w[7:4], c[3:0]};
			MN_BZ, MN_BNZ: return {w[31:28], c[23:20], w[23:20], c[19:0]};
			default: return {w[31:28], c, w[3:0]};
		endcase
	endfunction

	function automatic decode_t decode_relocate(input logic [OpW-1:0] opc,
		input logic [WordW-1:0] w, input logic [ConstW-1:0] nc,
		input logic [ConstW-1:0] base);
		decode_t d;
		logic [ConstW:0] sum;
		d = '{mnemonic_of(w), '0, w, STATUS_OK};
		if (d.code == MN_NONE) begin
			d.stat = STATUS_UNKNOWN;
		end else if (d.code < MN_CALL || d.code > MN_MVIA) begin
			d.stat = STATUS_NO_CONST;
		end else begin
			d.cval = const_field(d.code, w);
			if (opc == OP_REPLACE) begin
				d.word = with_const(d.code, w, nc);
				d.cval = nc;
			end else if (opc == OP_RELOCATE) begin
				sum = d.cval + base;
				if (sum[ConstW]) begin
					d.stat = STATUS_OVERFLOW;
				end else begin
					d.word = with_const(d.code, w, sum[ConstW-1:0]);
					d.cval = sum[ConstW-1:0];
				end
			end
		end
		return d;
	endfunction

	task automatic apb_xfer(input logic wr, input logic [PaddrW-1:0] addr,
		input logic [PdataW-1:0] data, output logic [PdataW-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (decodes_in_flight.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [PaddrW-1:0] addr, input logic [ConstW-1:0] v);
		logic [PdataW-1:0] rd;
		drain();
		apb_xfer(1'b1, addr, PdataW'(v), rd);
		if (addr == ADDR_BASE) reloc_base = v;
		apb_xfer(1'b0, ADDR_BASE, '0, rd);
		if (rd !== PdataW'(reloc_base)) begin
			$error("relocation_base: expected %h, got %h", PdataW'(reloc_base), rd);
			mismatches++;
		end
	endtask

	// one request; the expectation is queued at the edge where it is taken
	task automatic issue_word(input logic [OpW-1:0] opc, input logic [WordW-1:0] w,
		input logic [ConstW-1:0] nc, input bit typed, input decode_t want);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op <= opc;
		instr_word <= w;
		new_constant <= nc;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		decodes_in_flight.push_back(typed ? want : decode_relocate(opc, w, nc, reloc_base));
		@(negedge clk);
	endtask

	always @(posedge clk) begin : check_results
		decode_t want;
		if (out_valid === 1'b1 && !out_stall) begin
			if (decodes_in_flight.size() == 0) begin
				$error("result with no request pending: out_word %h", out_word);
				mismatches++;
			end else begin
				want = decodes_in_flight.pop_front();
				if (opcode_code !== want.code) begin
					$error("opcode_code: expected %0d, got %0d", want.code, opcode_code);
					mismatches++;
				end
				if (constant_value !== want.cval) begin
					$error("constant_value: expected %h, got %h", want.cval, constant_value);
					mismatches++;
				end
				if (out_word !== want.word) begin
					$error("out_word: expected %h, got %h", want.word, out_word);
					mismatches++;
				end
				if (status !== want.stat) begin
					$error("status: expected %0d, got %0d", want.stat, status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) === 1'b1 || (out_valid && !out_stall) === 1'b1 || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stall_results
		int hold;
		int seen;
		bit out_calm;
		seen = 0;
		out_calm = 1'b0;
		@(negedge clk);
		forever begin
			if (seen % 40 == 0) out_calm = ($urandom_range(0, 3) == 0);
			hold = out_calm ? 0 : $urandom_range(0, 14);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
			seen++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [OpW-1:0] opc;
		logic [WordW-1:0] w;
		logic [ConstW-1:0] nc;
		logic [ConstW-1:0] base;
		int pick;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_BASE: reg_write(ADDR_BASE, plan[i].nc);
				ROW_STRAY: reg_write(ADDR_STRAY, plan[i].nc);
				default: issue_word(plan[i].opc, plan[i].w, plan[i].nc, plan[i].typed, plan[i].want);
			endcase
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: base = '0;
				1: base = '1;
				2: base = 24'h000001;
				3: base = 24'h800000;
				4: base = ConstW'($urandom_range(0, 255));
				default: base = ConstW'($urandom);
			endcase
			reg_write(ADDR_BASE, base);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 25 == 0) in_calm = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 9);
				opc = (pick < 2) ? OP_DECODE : (pick < 5) ? OP_REPLACE :
					(pick < 9) ? OP_RELOCATE : OP_SPARE;
				// mostly words that carry a constant, the rest anywhere in the map
				w = $urandom;
				pick = $urandom_range(0, 9);
				if (pick < 6) w[31:28] = 4'($urandom_range(8, 13));
				else if (pick < 8) w[31:28] = 4'($urandom_range(0, 1));
				pick = $urandom_range(0, 7);
				nc = (pick == 0) ? '0 : (pick == 1) ? '1 : ConstW'($urandom);
				issue_word(opc, w, nc, 1'b0, UNTYPED);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
